FILE: design/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the serial frame detector.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned WinDepth     = 19;
  localparam int unsigned PatternBytes = 5;
  localparam int unsigned PatternWidth = PatternBytes * ByteWidth;
  localparam int unsigned AddrWidth    = 16;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = PatternWidth;

  // Window positions, oldest byte at position zero.
  localparam int unsigned StartPos     = 0;
  localparam int unsigned RecipientPos = 5;
  localparam int unsigned SenderPos    = 7;
  localparam int unsigned CommandPos   = 9;
  localparam int unsigned DataPos      = 10;
  localparam int unsigned EndPos       = 14;

  typedef logic [ByteWidth-1:0]    byte_t;
  typedef logic [PatternWidth-1:0] pattern_t;
  typedef logic [AddrWidth-1:0]    addr_t;
  typedef logic [CfgIdxWidth-1:0]  cfg_idx_t;
  typedef logic [CfgDataWidth-1:0] cfg_data_t;

  typedef enum logic [1:0] {
    StatusAccepted = 2'd0,
    StatusChecksum = 2'd1,
    StatusOther    = 2'd2
  } status_t;

  localparam cfg_idx_t CfgStartPattern = 2'd0;
  localparam cfg_idx_t CfgEndPattern   = 2'd1;
  localparam cfg_idx_t CfgOwnAddress   = 2'd2;
  localparam cfg_idx_t CfgBcastAddress = 2'd3;

  localparam addr_t BcastReset = '1;

  typedef struct packed {
    status_t status;
    addr_t   recipient;
    addr_t   sender;
    byte_t   command;
    byte_t   data_first;
    byte_t   data_second;
    byte_t   data_third;
    byte_t   data_fourth;
  } result_t;

  // Byte k of a pattern, the first sent byte in the top bits.
  function automatic byte_t pattern_byte(pattern_t pat, int unsigned k);
    pattern_byte = pat[(PatternBytes - 1 - k) * ByteWidth +: ByteWidth];
  endfunction

endpackage

FILE: design/sfd_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_byte_if
// Handshake channel that carries one received byte per transaction.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
  import sfd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: design/sfd_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_result_if
// Handshake channel that carries one detected frame per transaction.
// ----------------------------------------------------------------------------
interface sfd_result_if;
  import sfd_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  addr_t   recipient;
  addr_t   sender;
  byte_t   command;
  byte_t   data_first;
  byte_t   data_second;
  byte_t   data_third;
  byte_t   data_fourth;

  modport source (
    output valid, output status, output recipient, output sender, output command,
    output data_first, output data_second, output data_third, output data_fourth,
    input ready
  );
  modport sink (
    input valid, input status, input recipient, input sender, input command,
    input data_first, input data_second, input data_third, input data_fourth,
    output ready
  );
endinterface

FILE: design/sfd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_cfg_if
// Register write channel: one register index and its data per transaction.
// ----------------------------------------------------------------------------
interface sfd_cfg_if;
  import sfd_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  reg_index;
  cfg_data_t wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: design/sfd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_cell
// One byte stage of the receive window with its pattern compare.
// ----------------------------------------------------------------------------
module sfd_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift_en,
  input  sfd_pkg::byte_t din,
  input  sfd_pkg::byte_t expect_byte,
  input  logic           care,
  output sfd_pkg::byte_t dout,
  output logic           match
);
  import sfd_pkg::*;

  byte_t stage_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_byte <= '0;
    end else if (shift_en) begin
      stage_byte <= din;
    end
  end

  assign dout  = stage_byte;
  assign match = !care || (stage_byte == expect_byte);
endmodule

FILE: design/sfd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_out_buf
// Two-entry output buffer: a result register backed by a skid register.
// ----------------------------------------------------------------------------
module sfd_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfd_pkg::result_t push_data,
  output logic             full,
  sfd_result_if.source     frame
);
  import sfd_pkg::*;

  logic    out_valid;
  logic    skid_valid;
  result_t out_data;
  result_t skid_data;
  logic    out_fire;

  assign out_fire = out_valid && frame.ready;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || out_fire) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

  assign frame.valid       = out_valid;
  assign frame.status      = out_data.status;
  assign frame.recipient   = out_data.recipient;
  assign frame.sender      = out_data.sender;
  assign frame.command     = out_data.command;
  assign frame.data_first  = out_data.data_first;
  assign frame.data_second = out_data.data_second;
  assign frame.data_third  = out_data.data_third;
  assign frame.data_fourth = out_data.data_fourth;
endmodule

FILE: design/serial_frame_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_detector_core
// Frame detector over a sliding window of received bytes with XOR checksum.
// Throughput is one byte per cycle while the output buffer is not full, set by
// the 19-cell window shift; a frame result is pushed as its last byte is accepted.
// A two-entry output buffer keeps bytes flowing while one result is stalled.
// Synchronous reset clears the window and the checksum and loads the register
// reset values.
// ----------------------------------------------------------------------------
module serial_frame_detector_core (
  input  logic         clk,
  input  logic         rst,
  sfd_cfg_if.sink      cfg,
  sfd_byte_if.sink     rx,
  sfd_result_if.source frame
);
  import sfd_pkg::*;

  pattern_t start_pattern;
  pattern_t end_pattern;
  addr_t    own_address;
  addr_t    bcast_address;

  byte_t             win [WinDepth];
  byte_t             expect_bytes [WinDepth];
  logic [WinDepth-1:0] care_mask;
  logic [WinDepth-1:0] cell_match;
  byte_t             xsum;
  logic              accept;
  logic              buf_full;
  logic              cmd_ok;
  logic              hit;
  addr_t             rcpt;
  result_t           res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pattern <= '0;
      end_pattern   <= '0;
      own_address   <= '0;
      bcast_address <= BcastReset;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        CfgStartPattern: start_pattern <= cfg.wdata;
        CfgEndPattern:   end_pattern   <= cfg.wdata;
        CfgOwnAddress:   own_address   <= cfg.wdata[AddrWidth-1:0];
        CfgBcastAddress: bcast_address <= cfg.wdata[AddrWidth-1:0];
        default: ;
      endcase
    end
  end

  assign rx.ready = !buf_full;
  assign accept   = rx.valid && rx.ready;

  always_comb begin
    for (int unsigned k = 0; k < WinDepth; k++) begin
      expect_bytes[k] = '0;
      care_mask[k]    = 1'b0;
    end
    for (int unsigned k = 0; k < PatternBytes; k++) begin
      expect_bytes[StartPos + k] = pattern_byte(start_pattern, k);
      care_mask[StartPos + k]    = 1'b1;
      expect_bytes[EndPos + k]   = pattern_byte(end_pattern, k);
      care_mask[EndPos + k]      = 1'b1;
    end
  end

  for (genvar g = 0; g < WinDepth; g++) begin : g_cell
    byte_t cell_din;
    if (g == WinDepth - 1) begin : g_head
      assign cell_din = rx.rx_byte;
    end else begin : g_body
      assign cell_din = win[g + 1];
    end
    sfd_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift_en    (accept),
      .din         (cell_din),
      .expect_byte (expect_bytes[g]),
      .care        (care_mask[g]),
      .dout        (win[g]),
      .match       (cell_match[g])
    );
  end

  // Running XOR of the stored window: the byte entering is added, the oldest leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      xsum <= '0;
    end else if (accept) begin
      xsum <= xsum ^ rx.rx_byte ^ win[StartPos];
    end
  end

  assign cmd_ok = (win[CommandPos] != pattern_byte(start_pattern, 0))
               && (win[CommandPos] != pattern_byte(start_pattern, PatternBytes - 1))
               && (win[CommandPos] != pattern_byte(end_pattern, 0))
               && (win[CommandPos] != pattern_byte(end_pattern, PatternBytes - 1));
  assign hit  = (&cell_match) && cmd_ok;
  assign rcpt = {win[RecipientPos], win[RecipientPos + 1]};

  always_comb begin
    if (xsum != rx.rx_byte) begin
      res.status = StatusChecksum;
    end else if (rcpt != own_address && rcpt != bcast_address) begin
      res.status = StatusOther;
    end else begin
      res.status = StatusAccepted;
    end
    res.recipient   = rcpt;
    res.sender      = {win[SenderPos], win[SenderPos + 1]};
    res.command     = win[CommandPos];
    res.data_first  = win[DataPos];
    res.data_second = win[DataPos + 1];
    res.data_third  = win[DataPos + 2];
    res.data_fourth = win[DataPos + 3];
  end

  sfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && hit),
    .push_data (res),
    .full      (buf_full),
    .frame     (frame)
  );
endmodule
